// ----- hw/rtl/dsp_pkg.sv -----
// shared constants, codes and command/status types of the dust sensor core
package dsp_pkg;

  localparam int TimeW    = 32;
  localparam int SumW     = 26;
  localparam int SpanW    = 16;
  localparam int SpanUsW  = 26;
  localparam int RatioW   = 23;
  localparam int SqW      = 30;
  localparam int CubeW    = 36;
  localparam int AccW     = 49;
  localparam int DivNW    = 48;
  localparam int DivDW    = 22;
  localparam int CntW     = 6;
  localparam int MulAW    = 36;
  localparam int MulBW    = 24;
  localparam int ProdW    = MulAW + MulBW;
  localparam int WeightW  = 26;
  localparam int PmW      = 27;
  localparam int AqiW     = 18;
  localparam int NumW     = 26;
  localparam int WShift   = 12;
  localparam int RecipLoW = 18;
  localparam int WHiShift = 27;

  localparam logic [SumW-1:0]   SumMax    = '1;
  localparam logic [RatioW-1:0] RatioMax  = 23'd6553600;
  localparam logic [SpanW-1:0]  SpanReset = 16'd30000;
  localparam logic [CntW-1:0]   DivSteps  = 6'd48;

  localparam logic [MulBW-1:0] CoefLin   = 24'd940030;
  localparam logic [MulBW-1:0] CoefSq    = 24'd22400;
  localparam logic [MulBW-1:0] CoefCube  = 24'd1776;
  // ceil(2^45 / 625) split at bit 18
  localparam logic [MulBW-1:0] RecipLo   = 24'd95631;
  localparam logic [MulBW-1:0] RecipHi   = 24'd214748;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIV_R,
    OP_R_LATCH,
    OP_SQ,
    OP_CU,
    OP_N1,
    OP_N2,
    OP_N3,
    OP_W_LO,
    OP_W_HI,
    OP_PM,
    OP_SEG,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic ch;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic close_acc;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ----- hw/rtl/dsp_if.sv -----
// request and result channel interfaces
interface dsp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       channel;
  logic                       level;
  logic [dsp_pkg::TimeW-1:0]  time_us;

  modport source (output valid, channel, level, time_us, input ready);
  modport sink   (input valid, channel, level, time_us, output ready);
endinterface

interface dsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsp_pkg::WeightW-1:0]  weight_small;
  logic [dsp_pkg::WeightW-1:0]  weight_large;
  logic signed [dsp_pkg::PmW-1:0] pm25_weight;
  logic [dsp_pkg::AqiW-1:0]     air_index;

  modport source (output valid, weight_small, weight_large, pm25_weight, air_index,
                  input ready);
  modport sink   (input valid, weight_small, weight_large, pm25_weight, air_index,
                  output ready);
endinterface

// ----- hw/rtl/dsp_div.sv -----
// restoring divider, one quotient bit per cycle
module dsp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dsp_pkg::DivNW-1:0]  dividend_i,
  input  logic [dsp_pkg::DivDW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [dsp_pkg::DivNW-1:0]  quot_o
);
  import dsp_pkg::*;

  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dsr_q;
  logic [DivNW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivDW:0]   shifted;
  logic [DivDW:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quot_q[DivNW-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = DivSteps;
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DivDW-1:0] : shifted[DivDW-1:0];
      quot_d = {quot_q[DivNW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/dsp_datapath.sv -----
// edge bookkeeping, span timing and the weight/aqi arithmetic
module dsp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_data_i,
  input  dsp_pkg::cmd_t         cmd_i,
  output dsp_pkg::status_t      status_o,
  dsp_in_if.sink                in_i,
  dsp_out_if.source             out_o
);
  import dsp_pkg::*;

  localparam logic [2:0] SegZero    = 3'd0;
  localparam logic [2:0] SegDiv7    = 3'd1;
  localparam logic [2:0] SegDiv1024 = 3'd2;
  localparam logic [2:0] SegDiv256  = 3'd3;
  localparam logic [2:0] SegDiv5    = 3'd4;

  localparam logic [19:0] Recip7 = 20'd1171;
  localparam logic [20:0] Recip5 = 21'd1639;

  logic [SpanW-1:0]   span_q;
  logic [TimeW-1:0]   fall_q [2];
  logic [SumW-1:0]    sum_q [2];
  logic [SumW-1:0]    sum_next [2];
  logic [TimeW-1:0]   start_q;
  logic [SumW-1:0]    snap_q [2];
  logic [RatioW-1:0]  r_q;
  logic [SqW-1:0]     s_q;
  logic [CubeW-1:0]   c_q;
  logic signed [AccW-1:0] acc_q;
  logic [ProdW-RecipLoW-1:0] wlo_q;
  logic [WeightW-1:0] w_q [2];
  logic signed [PmW-1:0] pm_q;
  logic [AqiW-1:0]    aqi_q;

  logic               out_valid_q;
  logic [WeightW-1:0] out_w0_q, out_w1_q;
  logic signed [PmW-1:0] out_pm_q;
  logic [AqiW-1:0]    out_aqi_q;

  logic               acc_in;
  logic [TimeW-1:0]   fall_diff;
  logic [TimeW:0]     sum_ext;
  logic [SumW-1:0]    sum_sat;
  logic [SpanUsW-1:0] span_us;
  logic               close;
  logic [SpanW-1:0]   span_eff;
  logic [DivDW-1:0]   span_div;

  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod;
  logic [MulAW-1:0]   w_y;
  logic [ProdW-1:0]   w_sum;

  logic               div_start;
  logic [DivNW-1:0]   dividend;
  logic [DivDW-1:0]   divisor;
  logic               div_done;
  logic [DivNW-1:0]   quot;

  logic [NumW-1:0]    seg_p;
  logic [NumW-1:0]    seg_lo;
  logic [2:0]         seg_sel;
  logic [AqiW-1:0]    seg_base;
  logic [NumW-1:0]    seg_x;
  logic [15:0]        seg_x5;
  logic [19:0]        seg_m7;
  logic [20:0]        seg_m5;
  logic [AqiW-1:0]    seg_frac;
  logic [AqiW-1:0]    seg_aqi;

  assign acc_in = in_i.valid & cmd_i.take;

  // input edge: saturating low-time accumulation
  always_comb begin
    fall_diff = in_i.time_us - fall_q[in_i.channel];
    sum_ext   = {{(TimeW + 1 - SumW){1'b0}}, sum_q[in_i.channel]} + {1'b0, fall_diff};
    sum_sat   = (sum_ext > {{(TimeW + 1 - SumW){1'b0}}, SumMax}) ? SumMax
                                                                  : sum_ext[SumW-1:0];
    for (int i = 0; i < 2; i++) begin
      sum_next[i] = (in_i.level && (in_i.channel == i[0])) ? sum_sat : sum_q[i];
    end
    span_us  = {{(SpanUsW - SpanW){1'b0}}, span_q} * SpanUsW'(1000);
    close    = (in_i.time_us - start_q) > {{(TimeW - SpanUsW){1'b0}}, span_us};
    span_eff = (span_q == '0) ? SpanW'(1) : span_q;
    span_div = {{(DivDW - SpanW){1'b0}}, span_eff} * DivDW'(10);
  end

  // polynomial over 4096, zero when nonpositive
  assign w_y = acc_q[AccW-1] ? '0 : acc_q[AccW-2:WShift];

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ: begin
        mul_a = MulAW'(r_q);
        mul_b = MulBW'(r_q);
      end
      OP_CU: begin
        mul_a = MulAW'(s_q);
        mul_b = MulBW'(r_q);
      end
      OP_N1: begin
        mul_a = MulAW'(r_q);
        mul_b = CoefLin;
      end
      OP_N2: begin
        mul_a = MulAW'(s_q);
        mul_b = CoefSq;
      end
      OP_N3: begin
        mul_a = c_q;
        mul_b = CoefCube;
      end
      OP_W_LO: begin
        mul_a = w_y;
        mul_b = RecipLo;
      end
      OP_W_HI: begin
        mul_a = w_y;
        mul_b = RecipHi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // weight = (y * recip) >> 45, low half of the reciprocal taken first
  assign w_sum = prod + ProdW'(wlo_q);

  // aqi segment select from the registered pm value
  always_comb begin
    seg_p    = pm_q[NumW-1:0];
    seg_lo   = '0;
    seg_sel  = SegZero;
    seg_base = '0;
    if (pm_q[PmW-1]) begin
      seg_sel = SegZero;
    end else if (seg_p <= NumW'(8960)) begin
      seg_sel = SegDiv7;
    end else if (seg_p <= NumW'(19200)) begin
      seg_lo = NumW'(8960);   seg_sel = SegDiv1024; seg_base = AqiW'(50);
    end else if (seg_p <= NumW'(29440)) begin
      seg_lo = NumW'(19200);  seg_sel = SegDiv1024; seg_base = AqiW'(100);
    end else if (seg_p <= NumW'(38400)) begin
      seg_lo = NumW'(29440);  seg_sel = SegDiv7;    seg_base = AqiW'(150);
    end else if (seg_p <= NumW'(64000)) begin
      seg_lo = NumW'(38400);  seg_sel = SegDiv256;  seg_base = AqiW'(200);
    end else if (seg_p <= NumW'(128000)) begin
      seg_lo = NumW'(64000);  seg_sel = SegDiv5;    seg_base = AqiW'(300);
    end else begin
      seg_lo = NumW'(128000); seg_sel = SegDiv256;  seg_base = AqiW'(500);
    end
    seg_x  = seg_p - seg_lo;
    // 50x/8960 = (5x >> 7) / 7, 200x/64000 = (x >> 6) / 5
    seg_x5 = seg_x[15:0] * 16'd5;
    seg_m7 = {11'd0, seg_x5[15:7]} * Recip7;
    seg_m5 = {11'd0, seg_x[15:6]} * Recip5;
    case (seg_sel)
      SegDiv7:    seg_frac = AqiW'(seg_m7[19:13]);
      SegDiv1024: seg_frac = AqiW'(seg_x5[15:10]);
      SegDiv256:  seg_frac = seg_x[NumW-1:8];
      SegDiv5:    seg_frac = AqiW'(seg_m5[20:13]);
      default:    seg_frac = '0;
    endcase
    seg_aqi = seg_base + seg_frac;
  end

  // divider operands: low-time ratio only
  assign div_start = (cmd_i.op == OP_DIV_R);
  assign dividend  = {{(DivNW - SumW - 16){1'b0}}, snap_q[cmd_i.ch], 16'd0};
  assign divisor   = span_div;

  dsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SpanReset;
      fall_q[0]   <= '0;
      fall_q[1]   <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        span_q <= cfg_data_i;
      end
      if (acc_in) begin
        if (!in_i.level) begin
          fall_q[in_i.channel] <= in_i.time_us;
        end
        if (close) begin
          sum_q[0] <= '0;
          sum_q[1] <= '0;
          start_q  <= in_i.time_us;
        end else begin
          sum_q[0] <= sum_next[0];
          sum_q[1] <= sum_next[1];
        end
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && close) begin
      snap_q[0] <= sum_next[0];
      snap_q[1] <= sum_next[1];
    end
    case (cmd_i.op)
      OP_R_LATCH: r_q <= (quot > DivNW'(RatioMax)) ? RatioMax : quot[RatioW-1:0];
      OP_SQ:      s_q <= prod[16 +: SqW];
      OP_CU:      c_q <= prod[16 +: CubeW];
      OP_N1:      acc_q <= $signed({1'b0, prod[AccW-2:0]});
      OP_N2:      acc_q <= acc_q - $signed({1'b0, prod[AccW-2:0]});
      OP_N3:      acc_q <= acc_q + $signed({1'b0, prod[AccW-2:0]});
      OP_W_LO:    wlo_q <= prod[ProdW-1:RecipLoW];
      OP_W_HI:    w_q[cmd_i.ch] <= w_sum[WHiShift +: WeightW];
      OP_PM:      pm_q <= $signed({1'b0, w_q[0]}) - $signed({1'b0, w_q[1]});
      OP_SEG:     aqi_q <= seg_aqi;
      OP_OUT: begin
        out_w0_q  <= w_q[0];
        out_w1_q  <= w_q[1];
        out_pm_q  <= pm_q;
        out_aqi_q <= aqi_q;
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready          = cmd_i.take;
  assign out_o.valid         = out_valid_q;
  assign out_o.weight_small  = out_w0_q;
  assign out_o.weight_large  = out_w1_q;
  assign out_o.pm25_weight   = out_pm_q;
  assign out_o.air_index     = out_aqi_q;

  assign status_o.close_acc = acc_in & close;
  assign status_o.div_done  = div_done;
  assign status_o.out_busy  = out_valid_q;

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && close) |=> (sum_q[0] == '0 && sum_q[1] == '0))
    else $error("sums not cleared after span close");

  a_pm_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pm_q == $signed({1'b0, out_w0_q}) - $signed({1'b0, out_w1_q})))
    else $error("pm25 does not match weight difference");

  a_aqi_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pm_q[PmW-1]) |-> (out_aqi_q == '0))
    else $error("nonzero aqi for negative pm25");

endmodule

// ----- hw/rtl/dsp_ctrl.sv -----
// sequencer for the span-close computation
module dsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsp_pkg::status_t  status_i,
  output dsp_pkg::cmd_t     cmd_o
);
  import dsp_pkg::*;

  localparam logic [4:0] StIdle     = 5'd0;
  localparam logic [4:0] StRDivGo   = 5'd1;
  localparam logic [4:0] StRDivWait = 5'd2;
  localparam logic [4:0] StRLatch   = 5'd3;
  localparam logic [4:0] StSq       = 5'd4;
  localparam logic [4:0] StCu       = 5'd5;
  localparam logic [4:0] StN1       = 5'd6;
  localparam logic [4:0] StN2       = 5'd7;
  localparam logic [4:0] StN3       = 5'd8;
  localparam logic [4:0] StWLo      = 5'd9;
  localparam logic [4:0] StWHi      = 5'd10;
  localparam logic [4:0] StPm       = 5'd11;
  localparam logic [4:0] StSeg      = 5'd12;
  localparam logic [4:0] StOut      = 5'd13;

  logic [4:0] state_q, state_d;
  logic       ch_q, ch_d;

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    cmd_o.op   = OP_NONE;
    cmd_o.ch   = ch_q;
    cmd_o.take = 1'b0;
    unique case (state_q)
      StIdle: begin
        cmd_o.take = 1'b1;
        if (status_i.close_acc) begin
          ch_d    = 1'b0;
          state_d = StRDivGo;
        end
      end
      StRDivGo: begin
        cmd_o.op = OP_DIV_R;
        state_d  = StRDivWait;
      end
      StRDivWait: begin
        if (status_i.div_done) state_d = StRLatch;
      end
      StRLatch: begin
        cmd_o.op = OP_R_LATCH;
        state_d  = StSq;
      end
      StSq: begin
        cmd_o.op = OP_SQ;
        state_d  = StCu;
      end
      StCu: begin
        cmd_o.op = OP_CU;
        state_d  = StN1;
      end
      StN1: begin
        cmd_o.op = OP_N1;
        state_d  = StN2;
      end
      StN2: begin
        cmd_o.op = OP_N2;
        state_d  = StN3;
      end
      StN3: begin
        cmd_o.op = OP_N3;
        state_d  = StWLo;
      end
      StWLo: begin
        cmd_o.op = OP_W_LO;
        state_d  = StWHi;
      end
      StWHi: begin
        cmd_o.op = OP_W_HI;
        if (!ch_q) begin
          ch_d    = 1'b1;
          state_d = StRDivGo;
        end else begin
          state_d = StPm;
        end
      end
      StPm: begin
        cmd_o.op = OP_PM;
        state_d  = StSeg;
      end
      StSeg: begin
        cmd_o.op = OP_SEG;
        state_d  = StOut;
      end
      StOut: begin
        // hold until the result register is free
        if (!status_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_DIV_R) |=> !status_i.div_done)
    else $error("divider done right after start");

  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.close_acc |=> (state_q == StRDivGo && ch_q == 1'b0))
    else $error("span close did not start computation");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT) |-> !status_i.out_busy)
    else $error("result loaded over a pending result");

endmodule

// ----- hw/rtl/dust_sensor_pulse_aqi_core.sv -----
// top level of the dust sensor pulse occupancy / pm2.5 aqi core
//
// in_i carries pin edge requests (channel, level, time_us) on a valid/ready
// handshake; out_o carries one result (weights, pm2.5, aqi) per closed span.
// cfg_we_i / cfg_data_i write the span length in milliseconds; write only
// while the core is idle.
// An edge that does not close the span leaves the core idle with in_i.ready
// still high, so such requests can arrive back to back.
// An edge that closes the span starts a computation made of two passes
// (one per channel) through the one-bit-per-cycle 48-step ratio divider
// and the multiply steps (square, cube, three polynomial terms, two weight
// halves), plus 3 final steps (pm2.5, aqi segment, output load); in_i.ready
// is low for that time and the result is then valid in the output register.
// If out_o.ready is low the result waits in the output register; requests
// are still taken until the next span close, which then holds before
// loading its result until the register is free.
// Reset clears the edge times, sums and span start and sets the span to
// 30000 ms.
module dust_sensor_pulse_aqi_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  dsp_in_if.sink      in_i,
  dsp_out_if.source   out_o
);
  import dsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  dsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dsp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule
